### rtl/core/spi_nor_flash_command_sequencer_top_defines.svh
// Assertion macros used by the sequencer top.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SNFCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, disabled in reset.
`define SNFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

### rtl/core/snfcs_pkg.sv
package snfcs_pkg;

  localparam int MaxFrames = 6;
  localparam int AddrW     = 24;
  localparam int CountW    = 16;
  localparam int CapW      = 25;

  typedef enum logic [2:0] {
    CMD_WR_START = 3'd0,
    CMD_WR_BYTE  = 3'd1,
    CMD_RD_START = 3'd2,
    CMD_RD_BYTE  = 3'd3,
    CMD_SEC_ERASE = 3'd4,
    CMD_CHIP_ERASE = 3'd5,
    CMD_POWER_DOWN = 3'd6,
    CMD_WAKE     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SEQ   = 2'd2;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_PP    = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_SE    = 8'h20;
  localparam logic [7:0] OP_CE    = 8'hC7;
  localparam logic [7:0] OP_PD    = 8'hB9;
  localparam logic [7:0] OP_WAKE  = 8'hAB;
  localparam logic [7:0] DUMMY    = 8'hFF;

  typedef struct packed {
    logic       sends;
    logic [7:0] mosi_byte;
    logic       end_frame;
    logic       wait_busy;
    logic       capture;
  } frame_t;

  typedef struct packed {
    frame_t [MaxFrames-1:0] frames;
    logic [2:0]             count;
    logic [1:0]             status;
  } burst_t;

  typedef struct packed {
    mode_t             mode;
    logic [AddrW-1:0]  cur_address;
    logic [CountW-1:0] bytes_left;
    logic              page_open;
  } seq_state_t;

  function automatic frame_t mk_frame(logic [7:0] b, logic endf, logic waitb, logic cap);
    frame_t f;
    f.sends     = 1'b1;
    f.mosi_byte = b;
    f.end_frame = endf;
    f.wait_busy = waitb;
    f.capture   = cap;
    return f;
  endfunction

endpackage

### rtl/core/snfcs_decode.sv
module snfcs_decode #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  snfcs_pkg::seq_state_t       state,
  input  logic [snfcs_pkg::CapW-1:0]  capacity,
  input  logic [2:0]                  cmd,
  input  logic [snfcs_pkg::AddrW-1:0] address,
  input  logic [snfcs_pkg::CountW-1:0] count,
  input  logic [7:0]                  data_byte,
  input  logic [11:0]                 sector,
  output snfcs_pkg::seq_state_t       state_next,
  output snfcs_pkg::burst_t           burst
);

  localparam int PL     = $clog2(PAGE_BYTES);
  localparam int SB_LOG = $clog2(SECTOR_BYTES);
  localparam int EW     = (12 + SB_LOG + 1 > snfcs_pkg::CapW + 1) ?
                          12 + SB_LOG + 1 : snfcs_pkg::CapW + 1;

  logic [snfcs_pkg::CapW-1:0]   wr_end;
  logic [EW-1:0]                sec_base;
  logic [EW-1:0]                sec_end;
  logic [snfcs_pkg::AddrW-1:0]  se_addr;
  logic [snfcs_pkg::AddrW-1:0]  addr_inc;
  logic [snfcs_pkg::CountW-1:0] left_dec;
  logic                         close;
  snfcs_pkg::cmd_t              op;

  assign op       = snfcs_pkg::cmd_t'(cmd);
  assign wr_end   = {1'b0, address} + snfcs_pkg::CapW'(count);
  assign sec_base = EW'(sector) << SB_LOG;
  assign sec_end  = sec_base + EW'(SECTOR_BYTES);
  assign se_addr  = sec_base[snfcs_pkg::AddrW-1:0];
  assign addr_inc = state.cur_address + snfcs_pkg::AddrW'(1);
  assign left_dec = state.bytes_left - snfcs_pkg::CountW'(1);
  assign close    = (left_dec == '0) || (addr_inc[PL-1:0] == '0);

  always_comb begin
    state_next   = state;
    burst.frames = '0;
    burst.count  = 3'd1;
    burst.status = snfcs_pkg::STATUS_OK;
    if ((state.mode == snfcs_pkg::MODE_WRITE && op != snfcs_pkg::CMD_WR_BYTE) ||
        (state.mode == snfcs_pkg::MODE_READ && op != snfcs_pkg::CMD_RD_BYTE)) begin
      burst.status = snfcs_pkg::STATUS_SEQ;
    end else begin
      case (op)
        snfcs_pkg::CMD_WR_START: begin
          if (wr_end > capacity) begin
            burst.status = snfcs_pkg::STATUS_RANGE;
          end else if (count != '0) begin
            state_next.mode        = snfcs_pkg::MODE_WRITE;
            state_next.cur_address = address;
            state_next.bytes_left  = count;
            state_next.page_open   = 1'b0;
          end
        end
        snfcs_pkg::CMD_WR_BYTE: begin
          if (state.mode != snfcs_pkg::MODE_WRITE) begin
            burst.status = snfcs_pkg::STATUS_SEQ;
          end else begin
            if (!state.page_open) begin
              burst.frames[0] = snfcs_pkg::mk_frame(snfcs_pkg::OP_WREN, 1'b1, 1'b0, 1'b0);
              burst.frames[1] = snfcs_pkg::mk_frame(snfcs_pkg::OP_PP, 1'b0, 1'b0, 1'b0);
              burst.frames[2] = snfcs_pkg::mk_frame(state.cur_address[23:16], 1'b0, 1'b0, 1'b0);
              burst.frames[3] = snfcs_pkg::mk_frame(state.cur_address[15:8], 1'b0, 1'b0, 1'b0);
              burst.frames[4] = snfcs_pkg::mk_frame(state.cur_address[7:0], 1'b0, 1'b0, 1'b0);
              burst.frames[5] = snfcs_pkg::mk_frame(data_byte, close, close, 1'b0);
              burst.count     = 3'd6;
            end else begin
              burst.frames[0] = snfcs_pkg::mk_frame(data_byte, close, close, 1'b0);
            end
            state_next.page_open   = !close;
            state_next.bytes_left  = left_dec;
            state_next.cur_address = addr_inc;
            if (left_dec == '0) begin
              state_next.mode = snfcs_pkg::MODE_IDLE;
            end
          end
        end
        snfcs_pkg::CMD_RD_START: begin
          burst.frames[0] = snfcs_pkg::mk_frame(snfcs_pkg::OP_READ, 1'b0, 1'b0, 1'b0);
          burst.frames[1] = snfcs_pkg::mk_frame(address[23:16], 1'b0, 1'b0, 1'b0);
          burst.frames[2] = snfcs_pkg::mk_frame(address[15:8], 1'b0, 1'b0, 1'b0);
          burst.frames[3] = snfcs_pkg::mk_frame(address[7:0], count == '0, 1'b0, 1'b0);
          burst.count     = 3'd4;
          if (count != '0) begin
            state_next.mode        = snfcs_pkg::MODE_READ;
            state_next.cur_address = address;
            state_next.bytes_left  = count;
          end
        end
        snfcs_pkg::CMD_RD_BYTE: begin
          if (state.mode != snfcs_pkg::MODE_READ) begin
            burst.status = snfcs_pkg::STATUS_SEQ;
          end else begin
            burst.frames[0] = snfcs_pkg::mk_frame(snfcs_pkg::DUMMY, left_dec == '0, 1'b0, 1'b1);
            state_next.bytes_left  = left_dec;
            state_next.cur_address = addr_inc;
            if (left_dec == '0) begin
              state_next.mode = snfcs_pkg::MODE_IDLE;
            end
          end
        end
        snfcs_pkg::CMD_SEC_ERASE: begin
          if (sec_end > EW'(capacity)) begin
            burst.status = snfcs_pkg::STATUS_RANGE;
          end else begin
            burst.frames[0] = snfcs_pkg::mk_frame(snfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
            burst.frames[1] = snfcs_pkg::mk_frame(snfcs_pkg::OP_SE, 1'b0, 1'b0, 1'b0);
            burst.frames[2] = snfcs_pkg::mk_frame(se_addr[23:16], 1'b0, 1'b0, 1'b0);
            burst.frames[3] = snfcs_pkg::mk_frame(se_addr[15:8], 1'b0, 1'b0, 1'b0);
            burst.frames[4] = snfcs_pkg::mk_frame(se_addr[7:0], 1'b1, 1'b1, 1'b0);
            burst.count     = 3'd5;
          end
        end
        snfcs_pkg::CMD_CHIP_ERASE: begin
          burst.frames[0] = snfcs_pkg::mk_frame(snfcs_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
          burst.frames[1] = snfcs_pkg::mk_frame(snfcs_pkg::OP_CE, 1'b1, 1'b1, 1'b0);
          burst.count     = 3'd2;
        end
        snfcs_pkg::CMD_POWER_DOWN: begin
          burst.frames[0] = snfcs_pkg::mk_frame(snfcs_pkg::OP_PD, 1'b1, 1'b0, 1'b0);
        end
        default: begin
          burst.frames[0] = snfcs_pkg::mk_frame(snfcs_pkg::OP_WAKE, 1'b1, 1'b0, 1'b0);
        end
      endcase
    end
  end

endmodule

### rtl/core/snfcs_emit.sv
module snfcs_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  snfcs_pkg::burst_t burst_in,
  input  logic              out_ready,
  output logic              free,
  output logic              out_valid,
  output snfcs_pkg::frame_t frame,
  output logic [1:0]        status,
  output logic              last
);

  logic              busy;
  logic [2:0]        idx;
  snfcs_pkg::burst_t burst;

  assign out_valid = busy;
  assign frame     = burst.frames[idx];
  assign status    = burst.status;
  assign last      = (idx == burst.count - 3'd1);
  assign free      = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

endmodule

### rtl/core/spi_nor_flash_command_sequencer_top.sv
// Channel   Handshake              Payload
// request   in_valid / in_ready    cmd, address, count, data_byte, sector
// frame     out_valid / out_ready  sends, mosi_byte, end_frame, wait_busy,
//                                  capture, status, last
// config    cfg_we                 cfg_data (capacity_bytes)
// A request is decoded in the cycle it is taken; its frames show from the
// next cycle, one per cycle while out_ready is high; a request produces
// 1 to 6 frames, the header of a page being the longest.
// The frame buffer takes the next request in the cycle its last frame leaves.
// Synchronous reset clears mode, counters and buffer busy, and sets capacity to 8388608.
// Output stalls hold the current frame and backpressure the request side.
`include "spi_nor_flash_command_sequencer_top_defines.svh"

module spi_nor_flash_command_sequencer_top #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [24:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [23:0] address,
  input  logic [15:0] count,
  input  logic [7:0]  data_byte,
  input  logic [11:0] sector,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        sends,
  output logic [7:0]  mosi_byte,
  output logic        end_frame,
  output logic        wait_busy,
  output logic        capture,
  output logic [1:0]  status,
  output logic        last
);

  logic [snfcs_pkg::CapW-1:0] capacity_bytes;
  snfcs_pkg::seq_state_t      state;
  snfcs_pkg::seq_state_t      state_next;
  snfcs_pkg::burst_t          burst;
  snfcs_pkg::frame_t          frame;
  logic                       load;

  assign load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bytes <= 25'd8388608;
    end else if (cfg_we) begin
      capacity_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= snfcs_pkg::MODE_IDLE;
      state.cur_address <= '0;
      state.bytes_left  <= '0;
      state.page_open   <= 1'b0;
    end else if (load) begin
      state <= state_next;
    end
  end

  snfcs_decode #(
    .PAGE_BYTES  (PAGE_BYTES),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_decode (
    .state     (state),
    .capacity  (capacity_bytes),
    .cmd       (cmd),
    .address   (address),
    .count     (count),
    .data_byte (data_byte),
    .sector    (sector),
    .state_next(state_next),
    .burst     (burst)
  );

  snfcs_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst_in (burst),
    .out_ready(out_ready),
    .free     (in_ready),
    .out_valid(out_valid),
    .frame    (frame),
    .status   (status),
    .last     (last)
  );

  assign sends     = frame.sends;
  assign mosi_byte = frame.mosi_byte;
  assign end_frame = frame.end_frame;
  assign wait_busy = frame.wait_busy;
  assign capture   = frame.capture;

  `SNFCS_ASSERT_NEXT(a_load_shows, clk, rst, load, out_valid)
  `SNFCS_ASSERT_NOW(a_reply_alone, clk, rst, out_valid && !sends, last && !end_frame)
  `SNFCS_ASSERT_NOW(a_error_no_frame, clk, rst, out_valid && status != snfcs_pkg::STATUS_OK, !sends)
  `SNFCS_ASSERT_NOW(a_open_has_bytes, clk, rst, state.mode != snfcs_pkg::MODE_IDLE, state.bytes_left != '0)

endmodule
